// ===== hdl/crnp_pkg.sv =====
// Package for the cubic root Newton polish core.
// Holds the sequencer state type, sizing constants and Q16.48 saturation helpers.
// No dependencies.
`timescale 1ns / 1ps

package crnp_pkg;

  localparam int MAX_ITER    = 30;
  localparam int ITER_W      = $clog2(MAX_ITER + 1);
  localparam int FRAC_BITS   = 48;
  localparam int DIV_STEPS   = 64 + FRAC_BITS;
  localparam int CBRT_STEPS  = 54;
  localparam int CBRT_N_W    = 3 * CBRT_STEPS;
  localparam int CBRT_REM_W  = 114;
  localparam int CBRT_SQ_W   = 2 * CBRT_STEPS;
  localparam int CNT_W       = 7;
  localparam int TOL_W       = 63;
  localparam logic [TOL_W-1:0] TOL_RESET = 63'd256;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_MUL,
    ST_MULDONE,
    ST_DECIDE,
    ST_DIV,
    ST_DIVDONE,
    ST_CBRT,
    ST_CBRTDONE,
    ST_CHECK,
    ST_DONE
  } state_t;

  localparam logic [63:0] S_MAX = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] S_MIN = 64'h8000_0000_0000_0000;

  function automatic logic [63:0] mag(input logic [63:0] v);
    mag = v[63] ? (64'd0 - v) : v;
  endfunction

  function automatic logic [63:0] from_mag(input logic neg, input logic [63:0] m,
                                           input logic over);
    if (neg) begin
      from_mag = (over || m[63]) ? S_MIN : (64'd0 - m);
    end else begin
      from_mag = (over || m[63]) ? S_MAX : m;
    end
  endfunction

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      sat_add = s[64] ? S_MIN : S_MAX;
    end else begin
      sat_add = s[63:0];
    end
  endfunction

  function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) begin
      sat_sub = s[64] ? S_MIN : S_MAX;
    end else begin
      sat_sub = s[63:0];
    end
  endfunction

endpackage

// ===== hdl/cubic_root_newton_polish_core.sv =====
// Top level of the cubic root Newton polish core.
// Uses crnp_pkg for the state type, constants and saturation helpers.
`timescale 1ns / 1ps

// Polishes one real root of a cubic in signed Q16.48 by up to MAX_ITER Newton
// steps. A request is taken when start is high while busy is low; busy then
// stays high until the root is shown on root for one cycle with done high, and
// the receiver must take it in that cycle. Each Newton step runs five
// multiplies on one 32x32 multiplier (four partial products each), then,
// unless the derivative and c3 are both zero, a bit-serial divide, plus a
// digit cube root of the quotient when the derivative is zero. A new request
// is taken only once busy is low again. abs_tolerance is written through
// tol_we and tol_wdata, which the user must drive only while idle; the block
// itself does not enforce this.
module cubic_root_newton_polish_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic                      tol_we,
  input  logic [crnp_pkg::TOL_W-1:0] tol_wdata,
  input  logic signed [63:0]        coeff_0,
  input  logic signed [63:0]        coeff_1,
  input  logic signed [63:0]        coeff_2,
  input  logic signed [63:0]        coeff_3,
  input  logic signed [63:0]        initial_guess,
  output logic                      done,
  output logic signed [63:0]        root
);

  crnp_pkg::state_t state, state_next;

  logic [crnp_pkg::TOL_W-1:0] tol;
  logic [63:0] c0, c1, c2, c3, x, p, d, tmp;
  logic [crnp_pkg::ITER_W-1:0] iter;
  logic [2:0] op;

  logic [63:0]  ma, mb;
  logic         mneg;
  logic [1:0]   mcnt;
  logic [127:0] acc;

  logic [crnp_pkg::CNT_W-1:0] cnt;
  logic [crnp_pkg::DIV_STEPS-1:0] num;
  logic [63:0] dub, drem, dq;
  logic        dneg, dover, cbrt_mode;

  logic [crnp_pkg::CBRT_N_W-1:0]   nsh;
  logic [crnp_pkg::CBRT_REM_W-1:0] crem;
  logic [crnp_pkg::CBRT_STEPS-1:0] cy;
  logic [crnp_pkg::CBRT_SQ_W-1:0]  csq;
  logic        qneg;

  // multiplier partial product
  logic [31:0]  pa, pb;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [127:0] rnd;
  logic [63:0]  mres;

  always_comb begin
    pa = mcnt[0] ? ma[63:32] : ma[31:0];
    pb = mcnt[1] ? mb[63:32] : mb[31:0];
    pp = {32'd0, pa} * {32'd0, pb};
    case (mcnt)
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
    rnd  = acc + (128'd1 << (crnp_pkg::FRAC_BITS - 1));
    mres = crnp_pkg::from_mag(mneg, rnd[111:48], rnd[127:112] != 16'd0);
  end

  // divider step
  logic [63:0] dsh;
  logic        dge;
  logic [63:0] dres;
  always_comb begin
    dsh  = {drem[62:0], num[crnp_pkg::DIV_STEPS-1]};
    dge  = dsh >= dub;
    dres = crnp_pkg::from_mag(dneg, dq, dover);
  end

  // cube root digit step
  logic [crnp_pkg::CBRT_REM_W-1:0] csh, ctrial, cy_ext, csq_ext;
  logic                            cge;
  always_comb begin
    csh     = {crem[crnp_pkg::CBRT_REM_W-4:0], nsh[crnp_pkg::CBRT_N_W-1 -: 3]};
    cy_ext  = {{(crnp_pkg::CBRT_REM_W - crnp_pkg::CBRT_STEPS){1'b0}}, cy};
    csq_ext = {{(crnp_pkg::CBRT_REM_W - crnp_pkg::CBRT_SQ_W){1'b0}}, csq};
    ctrial  = (csq_ext << 3) + (csq_ext << 2) + (cy_ext << 2) + (cy_ext << 1)
              + {{(crnp_pkg::CBRT_REM_W - 1){1'b0}}, 1'b1};
    cge     = csh >= ctrial;
  end

  logic [63:0] cr;
  logic        stop;
  always_comb begin
    cr   = {{(64 - crnp_pkg::CBRT_STEPS){1'b0}}, cy};
    stop = crnp_pkg::mag(p) <= {1'b0, tol};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= crnp_pkg::ST_IDLE;
      tol   <= crnp_pkg::TOL_RESET;
    end else begin
      state <= state_next;
      if (tol_we) begin
        tol <= tol_wdata;
      end
    end
  end

  always_comb begin
    state_next = state;
    busy = state != crnp_pkg::ST_IDLE;
    done = state == crnp_pkg::ST_DONE;
    case (state)
      crnp_pkg::ST_IDLE:     if (start) state_next = crnp_pkg::ST_LAUNCH;
      crnp_pkg::ST_LAUNCH:   state_next = crnp_pkg::ST_MUL;
      crnp_pkg::ST_MUL:      if (mcnt == 2'd3) state_next = crnp_pkg::ST_MULDONE;
      crnp_pkg::ST_MULDONE:
        state_next = (op == 3'd4) ? crnp_pkg::ST_DECIDE : crnp_pkg::ST_LAUNCH;
      crnp_pkg::ST_DECIDE:
        state_next = (d != 64'd0 || c3 != 64'd0) ? crnp_pkg::ST_DIV : crnp_pkg::ST_CHECK;
      crnp_pkg::ST_DIV:
        if (cnt == crnp_pkg::CNT_W'(crnp_pkg::DIV_STEPS - 1)) begin
          state_next = crnp_pkg::ST_DIVDONE;
        end
      crnp_pkg::ST_DIVDONE:
        state_next = cbrt_mode ? crnp_pkg::ST_CBRT : crnp_pkg::ST_CHECK;
      crnp_pkg::ST_CBRT:
        if (cnt == crnp_pkg::CNT_W'(crnp_pkg::CBRT_STEPS - 1)) begin
          state_next = crnp_pkg::ST_CBRTDONE;
        end
      crnp_pkg::ST_CBRTDONE: state_next = crnp_pkg::ST_CHECK;
      crnp_pkg::ST_CHECK:
        state_next = (stop || iter == crnp_pkg::ITER_W'(crnp_pkg::MAX_ITER - 1)) ?
                     crnp_pkg::ST_DONE : crnp_pkg::ST_LAUNCH;
      crnp_pkg::ST_DONE:     state_next = crnp_pkg::ST_IDLE;
      default:               state_next = crnp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      crnp_pkg::ST_IDLE: begin
        c0   <= coeff_0;
        c1   <= coeff_1;
        c2   <= coeff_2;
        c3   <= coeff_3;
        x    <= initial_guess;
        iter <= '0;
        op   <= 3'd0;
      end
      crnp_pkg::ST_LAUNCH: begin
        logic [63:0] opa;
        opa = (op == 3'd0) ? c3 : (op[0] ? d : p);
        ma   <= crnp_pkg::mag(opa);
        mb   <= crnp_pkg::mag(x);
        mneg <= opa[63] ^ x[63];
        acc  <= '0;
        mcnt <= 2'd0;
      end
      crnp_pkg::ST_MUL: begin
        acc  <= acc + pp_sh;
        mcnt <= mcnt + 2'd1;
      end
      crnp_pkg::ST_MULDONE: begin
        case (op)
          3'd0: begin
            p <= crnp_pkg::sat_add(mres, c2);
            d <= c3;
          end
          3'd2: begin
            d <= crnp_pkg::sat_add(p, tmp);
            p <= crnp_pkg::sat_add(c1, mres);
          end
          3'd4: begin
            d <= crnp_pkg::sat_add(p, tmp);
            p <= crnp_pkg::sat_add(c0, mres);
          end
          default: tmp <= mres;
        endcase
        op <= (op == 3'd4) ? 3'd0 : op + 3'd1;
      end
      crnp_pkg::ST_DECIDE: begin
        logic [63:0] den;
        den = (d != 64'd0) ? d : c3;
        cbrt_mode <= d == 64'd0;
        num   <= {crnp_pkg::mag(p), {crnp_pkg::FRAC_BITS{1'b0}}};
        dub   <= crnp_pkg::mag(den);
        dneg  <= p[63] ^ den[63];
        drem  <= '0;
        dq    <= '0;
        dover <= 1'b0;
        cnt   <= '0;
      end
      crnp_pkg::ST_DIV: begin
        num   <= {num[crnp_pkg::DIV_STEPS-2:0], 1'b0};
        dover <= dover | dq[63];
        dq    <= {dq[62:0], dge};
        drem  <= dge ? dsh - dub : dsh;
        cnt   <= cnt + 1'b1;
      end
      crnp_pkg::ST_DIVDONE: begin
        if (!cbrt_mode) begin
          x <= crnp_pkg::sat_sub(x, dres);
        end
        qneg <= dres[63];
        nsh  <= {2'b00, crnp_pkg::mag(dres), 96'd0};
        crem <= '0;
        cy   <= '0;
        csq  <= '0;
        cnt  <= '0;
      end
      crnp_pkg::ST_CBRT: begin
        nsh <= {nsh[crnp_pkg::CBRT_N_W-4:0], 3'b000};
        if (cge) begin
          crem <= csh - ctrial;
          cy   <= {cy[crnp_pkg::CBRT_STEPS-2:0], 1'b1};
          csq  <= {csq[crnp_pkg::CBRT_SQ_W-3:0], 2'b00}
                  + {{(crnp_pkg::CBRT_SQ_W - crnp_pkg::CBRT_STEPS - 2){1'b0}}, cy, 2'b00}
                  + {{(crnp_pkg::CBRT_SQ_W - 1){1'b0}}, 1'b1};
        end else begin
          crem <= csh;
          cy   <= {cy[crnp_pkg::CBRT_STEPS-2:0], 1'b0};
          csq  <= {csq[crnp_pkg::CBRT_SQ_W-3:0], 2'b00};
        end
        cnt <= cnt + 1'b1;
      end
      crnp_pkg::ST_CBRTDONE: begin
        x <= crnp_pkg::sat_sub(x, qneg ? (64'd0 - cr) : cr);
      end
      crnp_pkg::ST_CHECK: begin
        iter <= iter + 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign root = x;

endmodule

// ===== hdl/crnp_checker.sv =====
// Port-level checks for the cubic root Newton polish core.
// Depends on cubic_root_newton_polish_core; bound to it below.
`timescale 1ns / 1ps

module crnp_port_props (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done without busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("request not taken up");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done && !busy)
    else $error("done longer than one cycle");

  a_release: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> $past(done))
    else $error("busy dropped without a result");

endmodule

bind cubic_root_newton_polish_core crnp_port_props u_crnp_port_props (
  .clk  (clk),
  .rst  (rst),
  .start(start),
  .busy (busy),
  .done (done)
);
